/* rtl/are_pkg.sv */
// ----------------------------------------------------------------------------
// are_pkg
// Shared constants and types of the attack/release envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package are_pkg;

  localparam int unsigned LEVEL_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 16;

  // Width of the phase code on the result beat
  localparam int unsigned PHASE_W = 2;

  typedef enum logic [PHASE_W-1:0] {
    PH_QUIET   = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_RELEASE = 2'd2
  } are_phase_e;

endpackage : are_pkg

`default_nettype wire

/* rtl/are_in_if.sv */
// ----------------------------------------------------------------------------
// are_in_if
// Input channel: tick or trigger beat with attack and release times.
// ----------------------------------------------------------------------------
`default_nettype none

interface are_in_if #(
  parameter int unsigned TIME_BITS = are_pkg::TIME_BITS_DEF
) ();

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [TIME_BITS-1:0] attack_ms;
  logic [TIME_BITS-1:0] release_ms;

  modport source (output valid, output mode, output attack_ms, output release_ms,
                  input ready);
  modport sink   (input valid, input mode, input attack_ms, input release_ms,
                  output ready);

endinterface : are_in_if

`default_nettype wire

/* rtl/are_out_if.sv */
// ----------------------------------------------------------------------------
// are_out_if
// Result channel: envelope level and phase after each input beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface are_out_if #(
  parameter int unsigned LEVEL_BITS = are_pkg::LEVEL_BITS_DEF
) ();

  import are_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic [PHASE_W-1:0]    phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);

endinterface : are_out_if

`default_nettype wire

/* rtl/are_muldiv.sv */
// ----------------------------------------------------------------------------
// are_muldiv
// Bit-serial floor(a * e / d): shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module are_muldiv #(
  parameter int unsigned LEVEL_BITS = are_pkg::LEVEL_BITS_DEF,
  parameter int unsigned TIME_BITS  = are_pkg::TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [LEVEL_BITS-1:0] a_i,
  input  wire logic [TIME_BITS:0]    e_i,
  input  wire logic [TIME_BITS-1:0]  d_i,
  output logic                       done_o,
  output logic [LEVEL_BITS-1:0]      quo_o
);

  import are_pkg::*;

  localparam int unsigned PW   = LEVEL_BITS + TIME_BITS + 1;
  localparam int unsigned CMAX = (TIME_BITS + 1 > LEVEL_BITS) ? TIME_BITS + 1 : LEVEL_BITS;
  localparam int unsigned CW   = $clog2(CMAX + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;

  logic [LEVEL_BITS-1:0] a_q, a_d;
  logic [TIME_BITS:0]    e_q, e_d;
  logic [TIME_BITS-1:0]  d_q, d_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [LEVEL_BITS-1:0] quo_q, quo_d;

  logic [LEVEL_BITS:0]   mul_sum;
  logic [PW-1:0]         prod_mul;
  logic [TIME_BITS:0]    rem_sh;
  logic [TIME_BITS:0]    rem_sub;
  logic                  ge;
  logic                  last;

  assign last     = (cnt_q == CW'(1));
  // accumulate into the top, shift the product right by one each step
  assign mul_sum  = {1'b0, prod_q[PW-1:TIME_BITS+1]} + {1'b0, (e_q[0] ? a_q : '0)};
  assign prod_mul = {mul_sum, prod_q[TIME_BITS:1]};
  // restoring divide step on the low product bits, MSB first
  assign rem_sh   = {rem_q, prod_q[LEVEL_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, d_q};
  assign ge       = (rem_sh >= {1'b0, d_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    e_d     = e_q;
    d_d     = d_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          e_d     = e_i;
          d_d     = d_i;
          prod_d  = '0;
          cnt_d   = CW'(TIME_BITS + 1);
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = prod_mul;
        e_d    = e_q >> 1;
        cnt_d  = cnt_q - CW'(1);
        if (last) begin
          // high part of a*e is below d, so it seeds the remainder
          rem_d   = prod_mul[PW-2:LEVEL_BITS];
          cnt_d   = CW'(LEVEL_BITS);
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        prod_d = prod_q << 1;
        rem_d  = ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        quo_d  = {quo_q[LEVEL_BITS-2:0], ge};
        cnt_d  = cnt_q - CW'(1);
        if (last) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    e_q    <= e_d;
    d_q    <= d_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule : are_muldiv

`default_nettype wire

/* rtl/attack_release_envelope.sv */
// ----------------------------------------------------------------------------
// attack_release_envelope
// Linear attack/release envelope generator for LED brightness.
// ----------------------------------------------------------------------------
// Every input beat is either a one-millisecond tick (mode 0) or a trigger
// (mode 1) carrying attack and release times in ticks; zero times count as
// one tick. Each input beat yields exactly one result beat with the level
// (all ones = full brightness) and phase after that beat. A trigger below
// full level restarts the attack from the current level; at full level it
// only latches the new release time. Beats that need no ramp arithmetic
// (triggers, quiet ticks, end of a ramp) go from accept straight to the
// push state and from there into the result register. A tick inside a ramp
// first waits in the busy state for the bit-serial multiply (TIME_BITS + 1
// steps) and restoring divide (LEVEL_BITS steps) in are_muldiv, which the
// accept starts; the busy state picks up its result and moves to the push
// state. A result still waiting in the output register holds back the push.
// One beat is worked at a time; input ready is high whenever the block is
// idle, even while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module attack_release_envelope #(
  parameter int unsigned LEVEL_BITS = are_pkg::LEVEL_BITS_DEF,
  parameter int unsigned TIME_BITS  = are_pkg::TIME_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  are_in_if.sink    in_i,
  are_out_if.source out_o
);

  import are_pkg::*;

  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL  = '1;
  localparam logic [TIME_BITS:0]    ELAPSED_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_PUSH = 3'b100
  } are_state_e;

  are_state_e state_q, state_d;

  // envelope state
  are_phase_e            phase_q, phase_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [LEVEL_BITS-1:0] start_q, start_d;
  logic [TIME_BITS:0]    elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0]  dur_q, dur_d;
  logic [TIME_BITS-1:0]  rel_q, rel_d;

  // output register
  logic                  ovalid_q, ovalid_d;
  logic [LEVEL_BITS-1:0] olevel_q, olevel_d;
  logic [PHASE_W-1:0]    ophase_q, ophase_d;

  logic                  accept;
  logic                  slot_free;
  logic [TIME_BITS:0]    el_inc;
  logic [TIME_BITS-1:0]  d_eff;
  logic [TIME_BITS-1:0]  atk_clamp;
  logic [TIME_BITS-1:0]  rel_clamp;
  logic [TIME_BITS-1:0]  relq_clamp;
  logic                  ramp_over;

  logic                  md_start;
  logic [LEVEL_BITS-1:0] md_a;
  logic                  md_done;
  logic [LEVEL_BITS-1:0] md_quo;

  assign accept    = in_i.valid & in_i.ready;
  assign slot_free = ~ovalid_q | out_o.ready;

  assign el_inc     = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign d_eff      = (dur_q == '0) ? TIME_BITS'(1) : dur_q;
  assign atk_clamp  = (in_i.attack_ms == '0) ? TIME_BITS'(1) : in_i.attack_ms;
  assign rel_clamp  = (in_i.release_ms == '0) ? TIME_BITS'(1) : in_i.release_ms;
  assign relq_clamp = (rel_q == '0) ? TIME_BITS'(1) : rel_q;
  assign ramp_over  = (el_inc > {1'b0, d_eff});

  // attack ramps the gap to full, release ramps the start level down
  assign md_a = (phase_q == PH_ATTACK) ? FULL_LEVEL - start_q : start_q;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    level_d   = level_q;
    start_d   = start_q;
    elapsed_d = elapsed_q;
    dur_d     = dur_q;
    rel_d     = rel_q;
    md_start  = 1'b0;
    ovalid_d  = ovalid_q & ~out_o.ready;
    olevel_d  = olevel_q;
    ophase_d  = ophase_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PUSH;
          if (in_i.mode) begin
            rel_d = rel_clamp;
            if (level_q != FULL_LEVEL) begin
              dur_d     = atk_clamp;
              start_d   = level_q;
              elapsed_d = '0;
              phase_d   = PH_ATTACK;
            end
          end else begin
            elapsed_d = el_inc;
            case (phase_q)
              PH_ATTACK: begin
                if (ramp_over) begin
                  level_d   = FULL_LEVEL;
                  start_d   = FULL_LEVEL;
                  elapsed_d = '0;
                  dur_d     = relq_clamp;
                  phase_d   = PH_RELEASE;
                end else begin
                  md_start = 1'b1;
                  state_d  = ST_BUSY;
                end
              end
              PH_RELEASE: begin
                if (ramp_over) begin
                  level_d = '0;
                  start_d = '0;
                  phase_d = PH_QUIET;
                end else begin
                  md_start = 1'b1;
                  state_d  = ST_BUSY;
                end
              end
              default: phase_d = PH_QUIET;
            endcase
          end
        end
      end
      ST_BUSY: begin
        if (md_done) begin
          level_d = (phase_q == PH_ATTACK) ? start_q + md_quo : start_q - md_quo;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          olevel_d = level_q;
          ophase_d = phase_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_QUIET;
      level_q   <= '0;
      start_q   <= '0;
      elapsed_q <= '0;
      dur_q     <= '0;
      rel_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      level_q   <= level_d;
      start_q   <= start_d;
      elapsed_q <= elapsed_d;
      dur_q     <= dur_d;
      rel_q     <= rel_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    olevel_q <= olevel_d;
    ophase_q <= ophase_d;
  end

  are_muldiv #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .e_i     (el_inc),
    .d_i     (d_eff),
    .done_o  (md_done),
    .quo_o   (md_quo)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.level = olevel_q;
  assign out_o.phase = ophase_q;

  // the serial unit only finishes while a ramp beat is outstanding
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == ST_BUSY))
    else $error("muldiv done outside busy state");

  // a trigger below full level always starts a fresh attack
  a_trig_attack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode && (level_q != FULL_LEVEL))
      |=> (phase_q == PH_ATTACK) && (elapsed_q == '0) && (dur_q != '0))
    else $error("trigger did not start attack");

  // a pushed result lands in the output register on the next edge
  a_push_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && slot_free)
      |=> out_o.valid && (out_o.level == $past(level_q)) && in_i.ready)
    else $error("result push lost");

endmodule : attack_release_envelope

`default_nettype wire

/* test/tb_attack_release_envelope.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_attack_release_envelope
// Self-checking bench for the linear attack/release envelope generator.
// ----------------------------------------------------------------------------
// Ticks and triggers go in on the input channel. Each accepted beat runs
// through a bit-exact envelope model. The level and phase that the model
// expects are queued and then compared with every result beat. A directed
// part covers quiet ticks, zero times, the trigger at full level and
// retriggers with the longest times. Random ramps follow under three
// valid/ready idle mixes.
// ----------------------------------------------------------------------------
module tb_attack_release_envelope;

  import are_pkg::*;

  localparam int unsigned LVL_W = 16;
  localparam int unsigned TIM_W = 16;
  localparam logic [LVL_W-1:0] FULL_SCALE = '1;
  localparam logic [TIM_W:0]   ELAPSED_TOP = '1;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    are_phase_e       phase;
  } env_result_t;

  logic clk_i;
  logic rst_ni;

  are_in_if  #(.TIME_BITS(TIM_W))  in_if ();
  are_out_if #(.LEVEL_BITS(LVL_W)) out_if ();

  attack_release_envelope #(
    .LEVEL_BITS(LVL_W),
    .TIME_BITS (TIM_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Envelope model state
  are_phase_e       env_phase;
  logic [LVL_W-1:0] env_level;
  logic [LVL_W-1:0] env_start;
  logic [TIM_W:0]   env_elapsed;
  logic [TIM_W-1:0] env_dur;
  logic [TIM_W-1:0] env_rel;

  env_result_t expected_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatches;
  int results_seen;
  int n_trig;
  int n_tick;

  function automatic logic [TIM_W-1:0] clamp_ticks(input logic [TIM_W-1:0] t);
    return (t == '0) ? TIM_W'(1) : t;
  endfunction

  // Advance the envelope by one accepted beat and return the level/phase after it
  function automatic env_result_t envelope_step(input logic trig,
                                                input logic [TIM_W-1:0] att,
                                                input logic [TIM_W-1:0] rel);
    longint unsigned d;
    longint unsigned el;
    longint unsigned st;
    env_result_t res;
    if (trig) begin
      env_rel = clamp_ticks(rel);
      // a trigger at full scale only latches the release time
      if (env_level != FULL_SCALE) begin
        env_dur     = clamp_ticks(att);
        env_start   = env_level;
        env_elapsed = '0;
        env_phase   = PH_ATTACK;
      end
    end else begin
      d = (env_dur == '0) ? 1 : longint'(env_dur);
      if (env_elapsed != ELAPSED_TOP) env_elapsed = env_elapsed + 1'b1;
      el = longint'(env_elapsed);
      st = longint'(env_start);
      case (env_phase)
        PH_ATTACK: begin
          if (el > d) begin
            env_level   = FULL_SCALE;
            env_start   = FULL_SCALE;
            env_elapsed = '0;
            env_dur     = clamp_ticks(env_rel);
            env_phase   = PH_RELEASE;
          end else begin
            env_level = LVL_W'(st + ((longint'(FULL_SCALE) - st) * el) / d);
          end
        end
        PH_RELEASE: begin
          if (el > d) begin
            env_level = '0;
            env_start = '0;
            env_phase = PH_QUIET;
          end else begin
            env_level = LVL_W'(st - (st * el) / d);
          end
        end
        default: ;  // quiet: a tick changes nothing
      endcase
    end
    res.level = env_level;
    res.phase = env_phase;
    return res;
  endfunction

  // Mostly short times so that ramps finish; some wide ones to toggle every bit
  function automatic logic [TIM_W-1:0] pick_time();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return TIM_W'($urandom_range(12));
    if (sel < 85) return TIM_W'($urandom_range(300, 13));
    return TIM_W'($urandom);
  endfunction

  task automatic note_mismatch(input string what, input env_result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected level %0d phase %0d, got level %0d phase %0d",
               $time, what, want.level, want.phase, out_if.level, out_if.phase);
  endtask

  // One beat on the input channel; the model is stepped at the accepting edge
  task automatic send_beat(input logic trig, input logic [TIM_W-1:0] att,
                           input logic [TIM_W-1:0] rel);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= trig;
    in_if.attack_ms  <= att;
    in_if.release_ms <= rel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(envelope_step(trig, att, rel));
    if (trig) n_trig++;
    else n_tick++;
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_beat(1'b0, TIM_W'($urandom), TIM_W'($urandom));
  endtask

  // Ticks before any trigger leave the block quiet
  task automatic test_quiet_tick();
    send_ticks(2);
  endtask

  // Zero times clamp to one tick; a trigger at full scale is ignored but its
  // release time is taken by the pending release
  task automatic test_zero_times_full_trigger();
    send_beat(1'b1, '0, '0);
    send_ticks(1);
    send_beat(1'b1, TIM_W'(5), TIM_W'(3));
    send_ticks(5);
  endtask

  // Longest times, retrigger inside attack and inside release
  task automatic test_retrigger_long();
    send_beat(1'b1, '1, '1);
    send_ticks(3);
    send_beat(1'b1, TIM_W'(2), '1);
    send_ticks(5);
    send_beat(1'b1, TIM_W'(1), TIM_W'(1));
    send_ticks(4);
  endtask

  task automatic test_random_ramps(input int n_items);
    int sent;
    int ticks;
    int a_eff;
    int r_eff;
    logic [TIM_W-1:0] att;
    logic [TIM_W-1:0] rel;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        // noise: any mode, any field value
        send_beat(1'($urandom_range(1)), TIM_W'($urandom), TIM_W'($urandom));
        sent++;
      end else begin
        att = pick_time();
        rel = pick_time();
        send_beat(1'b1, att, rel);
        sent++;
        a_eff = int'(clamp_ticks(att));
        r_eff = int'(clamp_ticks(rel));
        if (a_eff + r_eff <= 40) ticks = a_eff + r_eff + $urandom_range(3, 1);
        else ticks = $urandom_range(40, 1);
        repeat (ticks) begin
          // occasional retrigger lands in attack, release or at full scale
          if ($urandom_range(99) < 6) send_beat(1'b1, pick_time(), pick_time());
          else send_ticks(1);
          sent++;
        end
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    env_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        want = '0;
        note_mismatch("unexpected result beat", want);
      end else begin
        want = expected_q.pop_front();
        if (out_if.level !== want.level || out_if.phase !== want.phase)
          note_mismatch("result mismatch", want);
      end
    end
  end

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= snk_idle_pct);

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = 1'b0;
    in_if.attack_ms  = '0;
    in_if.release_ms = '0;
    out_if.ready     = 1'b0;
    src_idle_pct     = 8;
    snk_idle_pct     = 73;
    mismatches       = 0;
    results_seen     = 0;
    n_trig           = 0;
    n_tick           = 0;
    env_phase        = PH_QUIET;
    env_level        = '0;
    env_start        = '0;
    env_elapsed      = '0;
    env_dur          = '0;
    env_rel          = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_quiet_tick();
    test_zero_times_full_trigger();
    test_retrigger_long();
    test_random_ramps(460);
    src_idle_pct = 73;
    snk_idle_pct = 8;
    test_random_ramps(460);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_ramps(460);
    in_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d triggers and %0d ticks, %0d result beats checked, %0d mismatches",
             n_trig, n_tick, results_seen, mismatches);
    $display("Idle mixes: sender-light/receiver-heavy, reversed, and back-to-back");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

endmodule : tb_attack_release_envelope
